### sv/midi_note_arpeggiating_voice_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the arpeggiating voice allocator
// Concurrent checks; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_ARPEGGIATING_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define MIDI_NOTE_ARPEGGIATING_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define MNAVA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mnava: property violated");
`define MNAVA_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("mnava: forbidden condition");
`else
`define MNAVA_ASSERT(lbl, clk, rst_n, prop)
`define MNAVA_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### sv/mnava_pkg.sv
// ----------------------------------------------------------------------------
// mnava_pkg
// Types, opcodes and constants shared by the voice allocator modules.
// ----------------------------------------------------------------------------
package mnava_pkg;

  localparam int NOTE_W  = 7;
  localparam int COUNT_W = 3;
  localparam int TICK_W  = 7;

  localparam logic [7:0] SENSE_BYTE  = 8'hFE;
  localparam logic [7:0] STATUS_MASK = 8'hF0;
  localparam logic [7:0] STATUS_ON   = 8'h90;
  localparam logic [7:0] STATUS_OFF  = 8'h80;

  localparam logic [TICK_W-1:0] TICK_RESET = 7'd32;

  localparam logic [1:0] OP_NOP  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ON   = 2'd2;
  localparam logic [1:0] OP_OFF  = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NOTE_W-1:0] note;
  } op_t;

  function automatic logic [TICK_W-1:0] delay_lookup(input logic [COUNT_W-1:0] n);
    logic [TICK_W-1:0] d;
    case (n)
      3'd1:    d = 7'd64;
      3'd2:    d = 7'd32;
      3'd3:    d = 7'd21;
      3'd4:    d = 7'd16;
      3'd5:    d = 7'd13;
      3'd6:    d = 7'd10;
      default: d = 7'd0;
    endcase
    return d;
  endfunction

endpackage

### sv/mnava_if.sv
// ----------------------------------------------------------------------------
// mnava channel interfaces
// Valid/ready channels for incoming requests and outgoing speaker results.
// ----------------------------------------------------------------------------
interface mnava_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface mnava_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] sounding_note;
  logic       speaker_on;
  logic [2:0] voice_count;

  modport source (output valid, output sounding_note, output speaker_on,
                  output voice_count, input ready);
  modport sink   (input valid, input sounding_note, input speaker_on,
                  input voice_count, output ready);
endinterface

### sv/mnava_front.sv
// ----------------------------------------------------------------------------
// mnava_front
// Parses MIDI bytes and ticks into slot operations; tracks the armed note and
// velocity bytes.
// ----------------------------------------------------------------------------
module mnava_front (
  input  logic              clk,
  input  logic              rst_n,
  mnava_in_if.sink          in_chan,
  output mnava_pkg::op_t    op_o,
  output logic              op_valid_o,
  input  logic              op_ready_i
);
  import mnava_pkg::*;

  logic exp_on_r, exp_on_nxt;
  logic exp_off_r, exp_off_nxt;
  logic exp_vel_r, exp_vel_nxt;
  logic accept;
  logic [7:0] b;

  assign b          = in_chan.data_byte;
  assign in_chan.ready = op_ready_i;
  assign op_valid_o = in_chan.valid;
  assign accept     = in_chan.valid && op_ready_i;

  always_comb begin
    exp_on_nxt  = exp_on_r;
    exp_off_nxt = exp_off_r;
    exp_vel_nxt = exp_vel_r;
    op_o.kind   = OP_NOP;
    op_o.note   = b[NOTE_W-1:0];
    if (in_chan.command) begin
      op_o.kind = OP_TICK;
    end else if (b != SENSE_BYTE) begin
      exp_vel_nxt = 1'b0;
      if (exp_on_r) begin
        op_o.kind   = OP_ON;
        exp_on_nxt  = 1'b0;
        exp_vel_nxt = 1'b1;
      end else if (exp_off_r) begin
        op_o.kind   = OP_OFF;
        exp_off_nxt = 1'b0;
        exp_vel_nxt = 1'b1;
      end
      if ((b & STATUS_MASK) == STATUS_ON) begin
        exp_on_nxt = 1'b1;
      end else if ((b & STATUS_MASK) == STATUS_OFF) begin
        exp_off_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_on_r  <= 1'b0;
      exp_off_r <= 1'b0;
      exp_vel_r <= 1'b0;
    end else if (accept) begin
      exp_on_r  <= exp_on_nxt;
      exp_off_r <= exp_off_nxt;
      exp_vel_r <= exp_vel_nxt;
    end
  end

endmodule

### sv/mnava_fifo.sv
// ----------------------------------------------------------------------------
// mnava_fifo
// Two-entry operation queue between the parser and the voice engine.
// ----------------------------------------------------------------------------
module mnava_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  mnava_pkg::op_t    push_op_i,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  output mnava_pkg::op_t    pop_op_o,
  output logic              pop_valid_o,
  input  logic              pop_ready_i
);
  import mnava_pkg::*;

  op_t        mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign push_ready_o = (cnt_r != 2'd2);
  assign pop_valid_o  = (cnt_r != 2'd0);
  assign pop_op_o     = mem_r[rd_ptr_r];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/mnava_back.sv
// ----------------------------------------------------------------------------
// mnava_back
// Voice engine: note slots, tick countdown, arpeggio rotation, output register.
// ----------------------------------------------------------------------------
`include "midi_note_arpeggiating_voice_allocator_core_assert.svh"

module mnava_back #(
  parameter int VOICES = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mnava_pkg::op_t    op_i,
  input  logic              op_valid_i,
  output logic              op_ready_o,
  mnava_out_if.source       out_chan
);
  import mnava_pkg::*;

  localparam int PTR_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [COUNT_W-1:0] VOICES_C = COUNT_W'(VOICES);
  localparam logic [PTR_W:0]     VOICES_P = (PTR_W+1)'(VOICES);

  logic [NOTE_W-1:0]  slots_r [VOICES];
  logic [NOTE_W-1:0]  slots_nxt [VOICES];
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [TICK_W-1:0]  cd_r, cd_nxt;
  logic [NOTE_W-1:0]  cur_r, cur_nxt;
  logic               out_valid_r;
  logic [NOTE_W-1:0]  out_note_r;
  logic [COUNT_W-1:0] out_count_r;
  logic [VOICES-1:0]  occ;
  logic               take;
  logic               hit;
  logic [PTR_W:0]     sum;

  assign op_ready_o = !out_valid_r || out_chan.ready;
  assign take       = op_valid_i && op_ready_o;

  always_comb begin
    for (int j = 0; j < VOICES; j++) begin
      occ[j] = (slots_r[j] != '0);
    end
  end

  always_comb begin
    slots_nxt = slots_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    cd_nxt    = cd_r;
    cur_nxt   = cur_r;
    hit       = 1'b0;
    sum       = '0;
    case (op_i.kind)
      OP_ON: begin
        for (int i = 0; i < VOICES; i++) begin
          if (!hit && slots_r[i] == '0) begin
            hit          = 1'b1;
            slots_nxt[i] = op_i.note;
          end
        end
        if (hit && count_r < VOICES_C) count_nxt = count_r + 3'd1;
      end
      OP_OFF: begin
        for (int i = 0; i < VOICES; i++) begin
          if (!hit && slots_r[i] == op_i.note) begin
            hit          = 1'b1;
            slots_nxt[i] = '0;
          end
        end
        if (hit && count_r != '0) count_nxt = count_r - 3'd1;
      end
      OP_TICK: begin
        if (cd_r == '0) begin
          cd_nxt = delay_lookup(count_r);
          if (count_r != '0) begin
            for (int k = 1; k <= VOICES; k++) begin
              sum = {1'b0, ptr_r} + (PTR_W+1)'(k);
              if (sum >= VOICES_P) sum = sum - VOICES_P;
              if (!hit && (occ[sum[PTR_W-1:0]] || k == VOICES)) begin
                hit     = 1'b1;
                ptr_nxt = sum[PTR_W-1:0];
              end
            end
          end
        end else begin
          cd_nxt = cd_r - 7'd1;
        end
      end
      default: ;
    endcase
    if (count_nxt != '0) begin
      if (slots_nxt[ptr_nxt] != '0) cur_nxt = slots_nxt[ptr_nxt];
    end else begin
      cur_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) slots_r[i] <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      cd_r        <= TICK_RESET;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        slots_r     <= slots_nxt;
        count_r     <= count_nxt;
        ptr_r       <= ptr_nxt;
        cd_r        <= cd_nxt;
        cur_r       <= cur_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_note_r  <= cur_nxt;
      out_count_r <= count_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.sounding_note = out_note_r;
  assign out_chan.speaker_on    = (out_note_r != '0);
  assign out_chan.voice_count   = out_count_r;

  `MNAVA_NEVER(a_count_max, clk, rst_n, count_r > VOICES_C)
  `MNAVA_NEVER(a_ptr_range, clk, rst_n, {1'b0, ptr_r} >= VOICES_P)
  `MNAVA_ASSERT(a_silent_empty, clk, rst_n, (count_r == '0) |-> (cur_r == '0))
  `MNAVA_ASSERT(a_out_matches, clk, rst_n, (take && !$past(1'b0)) |=> (out_note_r == cur_r))

endmodule

### sv/midi_note_arpeggiating_voice_allocator_core.sv
// ----------------------------------------------------------------------------
// midi_note_arpeggiating_voice_allocator_core
// MIDI note parser and arpeggiating single-voice allocator for a speaker.
// ----------------------------------------------------------------------------
//  channel   dir   handshake     payload
//  in_chan   in    valid/ready   command, data_byte
//  out_chan  out   valid/ready   sounding_note, speaker_on, voice_count
//
//  One request per cycle sustained while out_chan is ready; one result per
//  request, in order. Each request is registered in the 2-entry queue after
//  the parser, then in the output register after the voice engine.
//  Reset is synchronous; all slots clear at once, no clearing pass.
//  A stalled output holds its register, then the queue fills, then in ready
//  drops.
module midi_note_arpeggiating_voice_allocator_core #(
  parameter int VOICES = 6
) (
  input  logic         clk,
  input  logic         rst_n,
  mnava_in_if.sink     in_chan,
  mnava_out_if.source  out_chan
);
  import mnava_pkg::*;

  op_t  front_op;
  logic front_valid, front_ready;
  op_t  back_op;
  logic back_valid, back_ready;

  mnava_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .op_o       (front_op),
    .op_valid_o (front_valid),
    .op_ready_i (front_ready)
  );

  mnava_fifo u_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_op_i    (front_op),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_op_o     (back_op),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready)
  );

  mnava_back #(
    .VOICES (VOICES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_i       (back_op),
    .op_valid_i (back_valid),
    .op_ready_o (back_ready),
    .out_chan   (out_chan)
  );

endmodule
